// ===== rtl/gsa_pkg.sv =====
// Shared types, codes and defaults for the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int INDEX_W        = 10;
    localparam int GEN_W          = 16;
    localparam int MAX_SLOTS_W    = 11;
    localparam int SLOTS_DEFAULT  = 1024;
    localparam int GEN_BITS_DEFAULT = 16;
    localparam logic [MAX_SLOTS_W-1:0] MAX_SLOTS_RESET = 11'd1024;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2,
        ST_REFUSED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] handle_index;
        logic [GEN_W-1:0]   handle_generation;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] result_index;
        logic [GEN_W-1:0]   result_generation;
        logic               result_valid;
        logic               is_live;
    } rsp_word_t;

endpackage

// ===== rtl/generational_slot_allocator.sv =====
// Top level of the generational slot allocator: command stage, slot table and free stack.
`timescale 1ns / 1ps

// Generational slot allocator. Takes one command word per cycle (allocate,
// release, query) unless a response waits with rsp_ready low, and returns
// one response word per command: acceptance loads the command stage and
// launches the table reads, retirement loads the response register. That
// rate rests on the single command stage, whose slot-table and free-stack
// reads are forwarded from the word ahead of it.
// Allocation pops the most recently released slot, else extends the
// high-water mark; once the high-water mark reaches min(max_slots, SLOTS)
// with nothing free it answers status full with the default handle (the
// first handle ever handed out). The slot table is treated as all-zero
// above the high-water mark, so there is no clearing pass after reset and
// the block is ready in the first cycle out of reset. Write max_slots only
// while no command is in flight.
module generational_slot_allocator #(
    parameter int SLOTS    = gsa_pkg::SLOTS_DEFAULT,
    parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  gsa_pkg::req_word_t                 req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output gsa_pkg::rsp_word_t                 rsp,
    input  logic                               cfg_wr_en,
    input  logic [gsa_pkg::MAX_SLOTS_W-1:0]    cfg_wr_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    // common compare width for counts, limits and incoming indexes
    localparam int CW    = (CNT_W > gsa_pkg::MAX_SLOTS_W) ? CNT_W : gsa_pkg::MAX_SLOTS_W;

    typedef struct packed {
        logic                alive;
        logic [GEN_BITS-1:0] gen;
    } slot_ent_t;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [GEN_BITS-1:0] gen;
    } stk_ent_t;

    // command stage
    logic               s2_valid_reg;
    gsa_pkg::req_word_t s2_word_reg;

    // response register
    logic               rsp_valid_reg;
    gsa_pkg::rsp_word_t rsp_word_reg;
    gsa_pkg::rsp_word_t rsp_word_next;

    // allocator state
    logic [gsa_pkg::MAX_SLOTS_W-1:0] max_slots_reg;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    high_water_reg, high_water_next;
    logic                default_set_reg, default_set_next;
    logic [IDX_W-1:0]    default_index_reg, default_index_next;
    logic [GEN_BITS-1:0] default_gen_reg, default_gen_next;

    // forwarding of the write made by the word ahead
    logic                slot_fwd_hit_reg;
    slot_ent_t           slot_fwd_data_reg;
    logic                stk_fwd_hit_reg;
    stk_ent_t            stk_fwd_data_reg;

    // RAM ports
    logic                slot_wr_en;
    logic [IDX_W-1:0]    slot_wr_addr;
    slot_ent_t           slot_wr_data;
    logic [IDX_W-1:0]    slot_rd_addr;
    slot_ent_t           slot_rd_data;
    logic                stk_wr_en;
    logic [IDX_W-1:0]    stk_wr_addr;
    stk_ent_t            stk_wr_data;
    logic [IDX_W-1:0]    stk_rd_addr;
    stk_ent_t            stk_rd_data;

    // handshake
    logic                retire;
    logic                accept;

    // stage decode
    logic [IDX_W-1:0]    s2_idx;
    logic [GEN_BITS-1:0] s2_gen;
    slot_ent_t           slot_ent;
    stk_ent_t            stk_top;
    logic                in_range;
    logic                live;
    logic                is_default;
    logic                table_full;
    logic [IDX_W-1:0]    alloc_idx;
    logic [GEN_BITS-1:0] alloc_gen;
    logic [GEN_BITS-1:0] bumped_gen;

    assign retire    = s2_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s2_valid_reg || retire;
    assign accept    = req_valid && req_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    gsa_ram #(
        .WIDTH ($bits(slot_ent_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (accept),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    gsa_ram #(
        .WIDTH ($bits(stk_ent_t)),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (accept),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // Read addresses launched with the accepted word: the slot it names and
    // the stack top as it stands after the word ahead has retired.
    assign slot_rd_addr = IDX_W'(req.handle_index);
    assign stk_rd_addr  = IDX_W'(free_count_next - CNT_W'(1));

    // Decode of the word in the command stage.
    assign s2_idx     = IDX_W'(s2_word_reg.handle_index);
    assign s2_gen     = GEN_BITS'(s2_word_reg.handle_generation);
    assign slot_ent   = slot_fwd_hit_reg ? slot_fwd_data_reg : slot_rd_data;
    assign stk_top    = stk_fwd_hit_reg ? stk_fwd_data_reg : stk_rd_data;
    // entries at or above the high-water mark read as never written
    assign in_range   = CW'(s2_word_reg.handle_index) < CW'(high_water_reg);
    assign live       = in_range && slot_ent.alive && (slot_ent.gen == s2_gen);
    assign is_default = default_set_reg && (s2_idx == default_index_reg)
                        && (s2_gen == default_gen_reg);
    assign table_full = (free_count_reg == '0)
                        && ((CW'(high_water_reg) >= CW'(max_slots_reg))
                            || (CW'(high_water_reg) >= CW'(SLOTS)));
    assign alloc_idx  = (free_count_reg != '0) ? stk_top.idx : IDX_W'(high_water_reg);
    assign alloc_gen  = (free_count_reg != '0) ? stk_top.gen : '0;
    assign bumped_gen = slot_ent.gen + GEN_BITS'(1);

    always_comb
    begin
        rsp_word_next      = '0;
        slot_wr_en         = 1'b0;
        slot_wr_addr       = s2_idx;
        slot_wr_data       = '0;
        stk_wr_en          = 1'b0;
        stk_wr_addr        = IDX_W'(free_count_reg);
        stk_wr_data        = '0;
        free_count_next    = free_count_reg;
        high_water_next    = high_water_reg;
        default_set_next   = default_set_reg;
        default_index_next = default_index_reg;
        default_gen_next   = default_gen_reg;

        case (s2_word_reg.command)
            gsa_pkg::CMD_ALLOC:
            begin
                if (table_full)
                begin
                    // answer with the default handle, if there is one yet
                    rsp_word_next.status = gsa_pkg::ST_FULL;
                    if (default_set_reg)
                    begin
                        rsp_word_next.result_index      = gsa_pkg::INDEX_W'(default_index_reg);
                        rsp_word_next.result_generation = gsa_pkg::GEN_W'(default_gen_reg);
                        rsp_word_next.result_valid      = 1'b1;
                    end
                end
                else
                begin
                    rsp_word_next.status            = gsa_pkg::ST_OK;
                    rsp_word_next.result_index      = gsa_pkg::INDEX_W'(alloc_idx);
                    rsp_word_next.result_generation = gsa_pkg::GEN_W'(alloc_gen);
                    rsp_word_next.result_valid      = 1'b1;
                    if (retire)
                    begin
                        slot_wr_en         = 1'b1;
                        slot_wr_addr       = alloc_idx;
                        slot_wr_data.alive = 1'b1;
                        slot_wr_data.gen   = alloc_gen;
                        if (free_count_reg != '0)
                        begin
                            free_count_next = free_count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            high_water_next = high_water_reg + CNT_W'(1);
                        end
                        if (!default_set_reg)
                        begin
                            default_set_next   = 1'b1;
                            default_index_next = alloc_idx;
                            default_gen_next   = alloc_gen;
                        end
                    end
                end
            end
            gsa_pkg::CMD_RELEASE:
            begin
                if (!live)
                begin
                    rsp_word_next.status = gsa_pkg::ST_NOT_LIVE;
                end
                else if (is_default)
                begin
                    rsp_word_next.status = gsa_pkg::ST_REFUSED;
                end
                else
                begin
                    rsp_word_next.status = gsa_pkg::ST_OK;
                    if (retire)
                    begin
                        // retire the slot: drop alive, bump generation, push index
                        slot_wr_en         = 1'b1;
                        slot_wr_data.alive = 1'b0;
                        slot_wr_data.gen   = bumped_gen;
                        if (CW'(free_count_reg) < CW'(SLOTS))
                        begin
                            stk_wr_en       = 1'b1;
                            stk_wr_data.idx = s2_idx;
                            stk_wr_data.gen = bumped_gen;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            gsa_pkg::CMD_QUERY:
            begin
                if (live)
                begin
                    rsp_word_next.status  = gsa_pkg::ST_OK;
                    rsp_word_next.is_live = 1'b1;
                end
                else
                begin
                    rsp_word_next.status = gsa_pkg::ST_NOT_LIVE;
                end
            end
            default:
            begin
                rsp_word_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            max_slots_reg     <= gsa_pkg::MAX_SLOTS_RESET;
            free_count_reg    <= '0;
            high_water_reg    <= '0;
            default_set_reg   <= 1'b0;
            default_index_reg <= '0;
            default_gen_reg   <= '0;
            slot_fwd_hit_reg  <= 1'b0;
            stk_fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (retire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                max_slots_reg <= cfg_wr_data;
            end

            free_count_reg    <= free_count_next;
            high_water_reg    <= high_water_next;
            default_set_reg   <= default_set_next;
            default_index_reg <= default_index_next;
            default_gen_reg   <= default_gen_next;

            // a write landing in the same cycle as the read is taken from here
            if (accept)
            begin
                slot_fwd_hit_reg <= slot_wr_en && (slot_wr_addr == slot_rd_addr);
                stk_fwd_hit_reg  <= stk_wr_en;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_word_reg       <= req;
            slot_fwd_data_reg <= slot_wr_data;
            stk_fwd_data_reg  <= stk_wr_data;
        end
        if (retire)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

`ifndef SYNTHESIS
    // free slots are always slots that were once created
    a_free_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= high_water_reg)
        else $error("free count above high-water mark");

    a_hw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(high_water_reg) <= CW'(SLOTS))
        else $error("high-water mark above table size");

    // a full answer creates no slot and frees none
    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (retire && (s2_word_reg.command == gsa_pkg::CMD_ALLOC) && table_full)
        |=> ($stable(high_water_reg) && $stable(free_count_reg)))
        else $error("full allocation changed allocator state");

    // back-pressure only when both the stage and the response are occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s2_valid_reg && rsp_valid_reg && !rsp_ready))
        else $error("command stage stalled without cause");
`endif

endmodule

// ===== rtl/gsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
